// ----- src/les_pkg.sv -----
// Package for the LED effect sequencer: effect codes, register indexes,
// the frame record passed between the effect core and the top level,
// and the colour helper functions. No dependencies.
`default_nettype none

package les_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FADE_INTERVAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PULSES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RED       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_GREEN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_BLUE      = 3'd6;

    localparam logic [1:0] EFF_IDLE  = 2'd0;
    localparam logic [1:0] EFF_FLASH = 2'd1;
    localparam logic [1:0] EFF_RED   = 2'd2;

    localparam logic [7:0] LEVEL_LOW   = 8'd50;
    localparam logic [7:0] LEVEL_HIGH  = 8'd150;
    localparam logic [7:0] LEVEL_STEP  = 8'd5;
    localparam logic [8:0] RED_LOW     = 9'd50;
    localparam logic [8:0] RED_TOP     = 9'd255;
    localparam logic [8:0] RED_STEP    = 9'd20;
    localparam logic [7:0] FULL        = 8'd255;
    localparam logic [7:0] RECIP_FIVE  = 8'd205;

    typedef struct packed {
        logic       valid;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] level;
        logic [1:0] effect;
    } t_frame;

    // step one fifth of the way toward the target, truncating toward zero
    function automatic logic [7:0] glide(input logic [7:0] cur, input logic [7:0] tgt);
        logic [7:0]  mag;
        logic [15:0] prod;
        logic [7:0]  q;
        mag  = (tgt >= cur) ? (tgt - cur) : (cur - tgt);
        prod = mag * RECIP_FIVE;
        q    = {2'b00, prod[15:10]};
        return (tgt >= cur) ? (cur + q) : (cur - q);
    endfunction

    function automatic logic [7:0] scale_video(input logic [7:0] c, input logic [7:0] s);
        logic [15:0] prod;
        prod = c * s;
        return prod[15:8] + {7'd0, (c != 8'd0) && (s != 8'd0)};
    endfunction

endpackage

`default_nettype wire

// ----- src/les_if.sv -----
// Request channel interfaces for the LED effect sequencer: tick input
// and LED frame output, each with valid/ready. No dependencies.
`default_nettype none

interface les_in_if;
    logic valid;
    logic ready;
    logic motor_moving;

    modport source (output valid, output motor_moving, input ready);
    modport sink   (input valid, input motor_moving, output ready);
endinterface

interface les_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] led_red;
    logic [7:0] led_green;
    logic [7:0] led_blue;
    logic [1:0] effect;

    modport source (output valid, output led_red, output led_green, output led_blue,
                     output effect, input ready);
    modport sink   (input valid, input led_red, input led_green, input led_blue,
                     input effect, output ready);
endinterface

`default_nettype wire

// ----- src/les_core.sv -----
// Effect core: configuration registers, timers and effect state; turns
// one tick into an unscaled frame. Depends on les_pkg.
`default_nettype none

module les_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [les_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [les_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_step,
    input  wire logic                           i_moving,
    output les_pkg::t_frame                     o_frame
);

    logic [9:0]  r_fade_int, r_pulse_int;
    logic [10:0] r_flash_int;
    logic [3:0]  r_flash_pulses;
    logic [7:0]  r_idle_red, r_idle_green, r_idle_blue;

    logic [15:0] r_fade_timer, n_fade_timer, r_flash_timer, n_flash_timer;
    logic [7:0]  r_glide_red, n_glide_red, r_glide_green, n_glide_green;
    logic [7:0]  r_glide_blue, n_glide_blue;
    logic [7:0]  r_fade_level, n_fade_level;
    logic        r_fade_rising, n_fade_rising;
    logic [8:0]  r_red_level, n_red_level;
    logic        r_red_rising, n_red_rising;
    logic        r_flash_active, n_flash_active;
    logic [4:0]  r_flash_edges, n_flash_edges;
    logic        r_flashes_done, n_flashes_done;

    logic [15:0] fade_inc, flash_inc;
    logic [7:0]  white;

    always_comb begin
        fade_inc  = (r_fade_timer == 16'hFFFF) ? r_fade_timer : r_fade_timer + 16'd1;
        flash_inc = (r_flash_timer == 16'hFFFF) ? r_flash_timer : r_flash_timer + 16'd1;

        n_fade_timer   = fade_inc;
        n_flash_timer  = flash_inc;
        n_glide_red    = r_glide_red;
        n_glide_green  = r_glide_green;
        n_glide_blue   = r_glide_blue;
        n_fade_level   = r_fade_level;
        n_fade_rising  = r_fade_rising;
        n_red_level    = r_red_level;
        n_red_rising   = r_red_rising;
        n_flash_active = r_flash_active;
        n_flash_edges  = r_flash_edges;
        n_flashes_done = r_flashes_done;
        white          = 8'd0;

        o_frame = '0;

        if (!i_moving) begin
            n_flashes_done = 1'b0;
            if (fade_inc >= {6'd0, r_fade_int}) begin
                n_fade_timer  = 16'd0;
                n_glide_red   = les_pkg::glide(r_glide_red, r_idle_red);
                n_glide_green = les_pkg::glide(r_glide_green, r_idle_green);
                n_glide_blue  = les_pkg::glide(r_glide_blue, r_idle_blue);
                n_fade_level  = r_fade_rising ? r_fade_level + les_pkg::LEVEL_STEP
                                              : r_fade_level - les_pkg::LEVEL_STEP;
                if (n_fade_level >= les_pkg::LEVEL_HIGH) n_fade_rising = 1'b0;
                if (n_fade_level <= les_pkg::LEVEL_LOW)  n_fade_rising = 1'b1;
                o_frame.valid  = 1'b1;
                o_frame.red    = n_glide_red;
                o_frame.green  = n_glide_green;
                o_frame.blue   = n_glide_blue;
                o_frame.level  = n_fade_level;
                o_frame.effect = les_pkg::EFF_IDLE;
            end
        end else if (!r_flashes_done) begin
            if (!r_flash_active) begin
                n_flash_timer  = 16'd0;
                n_flash_edges  = 5'd0;
                n_flash_active = 1'b1;
            end
            if (n_flash_timer >= {5'd0, r_flash_int}) begin
                n_flash_timer = 16'd0;
                n_flash_edges = n_flash_edges + 5'd1;
                white         = n_flash_edges[0] ? les_pkg::FULL : 8'd0;
                if (n_flash_edges >= {r_flash_pulses, 1'b0}) begin
                    n_flash_active = 1'b0;
                    n_flashes_done = 1'b1;
                end
                o_frame.valid  = 1'b1;
                o_frame.red    = white;
                o_frame.green  = white;
                o_frame.blue   = white;
                o_frame.level  = white;
                o_frame.effect = les_pkg::EFF_FLASH;
            end
        end else begin
            if (fade_inc >= {6'd0, r_pulse_int}) begin
                n_fade_timer = 16'd0;
                n_red_level  = r_red_rising ? r_red_level + les_pkg::RED_STEP
                                            : r_red_level - les_pkg::RED_STEP;
                if (n_red_level >= les_pkg::RED_TOP) n_red_rising = 1'b0;
                if (n_red_level <= les_pkg::RED_LOW) n_red_rising = 1'b1;
                o_frame.valid  = 1'b1;
                o_frame.red    = les_pkg::FULL;
                o_frame.level  = n_red_level[8] ? les_pkg::FULL : n_red_level[7:0];
                o_frame.effect = les_pkg::EFF_RED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_int     <= 10'd30;
            r_pulse_int    <= 10'd30;
            r_flash_int    <= 11'd150;
            r_flash_pulses <= 4'd3;
            r_idle_red     <= 8'd0;
            r_idle_green   <= 8'd0;
            r_idle_blue    <= 8'd255;
            r_fade_timer   <= 16'd0;
            r_flash_timer  <= 16'd0;
            r_glide_red    <= 8'd0;
            r_glide_green  <= 8'd0;
            r_glide_blue   <= 8'd255;
            r_fade_level   <= les_pkg::LEVEL_LOW;
            r_fade_rising  <= 1'b1;
            r_red_level    <= les_pkg::RED_LOW;
            r_red_rising   <= 1'b1;
            r_flash_active <= 1'b0;
            r_flash_edges  <= 5'd0;
            r_flashes_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    les_pkg::CFG_FADE_INTERVAL:  r_fade_int     <= i_cfg_data[9:0];
                    les_pkg::CFG_PULSE_INTERVAL: r_pulse_int    <= i_cfg_data[9:0];
                    les_pkg::CFG_FLASH_INTERVAL: r_flash_int    <= i_cfg_data;
                    les_pkg::CFG_FLASH_PULSES:   r_flash_pulses <= i_cfg_data[3:0];
                    les_pkg::CFG_IDLE_RED:       r_idle_red     <= i_cfg_data[7:0];
                    les_pkg::CFG_IDLE_GREEN:     r_idle_green   <= i_cfg_data[7:0];
                    les_pkg::CFG_IDLE_BLUE:      r_idle_blue    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_step) begin
                r_fade_timer   <= n_fade_timer;
                r_flash_timer  <= n_flash_timer;
                r_glide_red    <= n_glide_red;
                r_glide_green  <= n_glide_green;
                r_glide_blue   <= n_glide_blue;
                r_fade_level   <= n_fade_level;
                r_fade_rising  <= n_fade_rising;
                r_red_level    <= n_red_level;
                r_red_rising   <= n_red_rising;
                r_flash_active <= n_flash_active;
                r_flash_edges  <= n_flash_edges;
                r_flashes_done <= n_flashes_done;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/led_effect_sequencer.sv -----
// LED effect sequencer top level: tick input register, effect core,
// frame register, brightness scaling and output register.
// Depends on les_pkg, les_if and les_core.
//
// Usage:
//   i_in carries one request per millisecond tick with motor_moving.
//   o_out carries an LED frame (led_red, led_green, led_blue, effect)
//   only on ticks that update the LEDs; other ticks give no request.
//   i_cfg_we/i_cfg_idx/i_cfg_data write one register per cycle; the user
//   must write only while no tick is in flight; the block does not check.
//   A frame passes from the tick input register through the effect
//   update into the frame register, then through brightness scaling
//   into the output register; any stage can hold under a stall.
//   One tick is taken per cycle while the receiver accepts frames;
//   the effect update and the scaling stage are each registered.
//   Reset clears all effect state to the idle fade start and loads the
//   register defaults.
//   When the receiver stalls, the frame holds on o_out and the stages
//   behind it keep filling until each holds a request; i_in.ready then
//   drops.
`default_nettype none

module led_effect_sequencer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    les_in_if.sink                              i_in,
    les_out_if.source                           o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [les_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [les_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic            r_in_v, r_in_moving;
    logic            r_mid_v;
    les_pkg::t_frame r_mid;
    les_pkg::t_frame core_frame;
    logic            r_out_v;
    logic [7:0]      r_out_red, r_out_green, r_out_blue;
    logic [1:0]      r_out_effect;

    logic out_free, mid_free, step, out_load, in_take;

    assign out_free = !r_out_v || o_out.ready;
    assign out_load = r_mid_v && out_free;
    assign mid_free = !r_mid_v || out_free;
    assign step     = r_in_v && mid_free;
    assign i_in.ready = !r_in_v || mid_free;
    assign in_take  = i_in.valid && i_in.ready;

    les_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_moving   (r_in_moving),
        .o_frame    (core_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_mid_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (in_take) r_in_v <= 1'b1;
            else if (step) r_in_v <= 1'b0;

            if (step) r_mid_v <= core_frame.valid;
            else if (out_load) r_mid_v <= 1'b0;

            if (out_load) r_out_v <= 1'b1;
            else if (o_out.ready) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) r_in_moving <= i_in.motor_moving;
        if (step) r_mid <= core_frame;
        if (out_load) begin
            r_out_red    <= les_pkg::scale_video(r_mid.red, r_mid.level);
            r_out_green  <= les_pkg::scale_video(r_mid.green, r_mid.level);
            r_out_blue   <= les_pkg::scale_video(r_mid.blue, r_mid.level);
            r_out_effect <= r_mid.effect;
        end
    end

    assign o_out.valid     = r_out_v;
    assign o_out.led_red   = r_out_red;
    assign o_out.led_green = r_out_green;
    assign o_out.led_blue  = r_out_blue;
    assign o_out.effect    = r_out_effect;

endmodule

`default_nettype wire

// ----- verif/led_effect_sequencer_tb.sv -----
// Self-checking testbench for led_effect_sequencer: directed table, then random tick runs
// over many register settings, checked against an in-bench model of the effect sequencer.
// Depends on les_pkg, les_if and the led_effect_sequencer RTL.
`timescale 1ns / 100ps

module led_effect_sequencer_tb;

    localparam logic [les_pkg::CFG_IDX_W-1:0] CFG_NONE = 3'd7;
    localparam int OUT_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_PHASES      = 12;
    localparam int PHASE_TICKS     = 45;
    localparam int EXTREME_TICKS   = 40;
    localparam int PLAN_LEN        = 20;

    typedef struct packed {
        logic [7:0] led_red;
        logic [7:0] led_green;
        logic [7:0] led_blue;
        logic [1:0] effect;
    } t_led_frame;

    typedef struct packed {
        logic                           is_cfg;
        logic [les_pkg::CFG_IDX_W-1:0]  idx;
        logic [les_pkg::CFG_DATA_W-1:0] data;
        logic                           moving;
        logic [7:0]                     rep;
        logic                           typed;
        t_led_frame                     frm;
    } t_step_row;

    localparam t_led_frame FRAME_NONE       = '0;
    localparam t_led_frame FRAME_WHITE      = '{8'd255, 8'd255, 8'd255, les_pkg::EFF_FLASH};
    localparam t_led_frame FRAME_BLACK      = '{8'd0, 8'd0, 8'd0, les_pkg::EFF_FLASH};
    localparam t_led_frame FRAME_RESET_GLOW = '{8'd0, 8'd0, 8'd55, les_pkg::EFF_IDLE};
    localparam t_led_frame FRAME_RED_FIRST  = '{8'd70, 8'd0, 8'd0, les_pkg::EFF_RED};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [les_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [les_pkg::CFG_DATA_W-1:0] cfg_data;

    les_in_if  in_ch ();
    les_out_if out_ch ();

    led_effect_sequencer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // model registers
    logic [9:0]  m_fade_ivl;
    logic [9:0]  m_pulse_ivl;
    logic [10:0] m_flash_ivl;
    logic [3:0]  m_flash_count;
    logic [7:0]  m_tgt_red, m_tgt_green, m_tgt_blue;

    // model effect state
    logic [15:0] m_fade_tmr, m_flash_tmr;
    logic [7:0]  m_col_red, m_col_green, m_col_blue;
    logic [7:0]  m_bright;
    logic        m_bright_up;
    logic [8:0]  m_red_lvl;
    logic        m_red_up;
    logic        m_flash_on;
    logic [4:0]  m_flash_edges;
    logic        m_flash_done;

    t_led_frame expected_frames [$];
    t_led_frame oldest;
    int         mismatches = 0;
    int         quiet = 0;
    bit         no_idle = 1'b0;
    bit         hold_out = 1'b0;

    t_step_row plan [PLAN_LEN] = '{
        '{1'b0, CFG_NONE, 11'd0, 1'b0, 8'd29, 1'b0, FRAME_NONE},
        '{1'b0, CFG_NONE, 11'd0, 1'b0, 8'd1, 1'b1, FRAME_RESET_GLOW},
        '{1'b1, les_pkg::CFG_FADE_INTERVAL, 11'd0, 1'b0, 8'd0, 1'b0, FRAME_NONE},
        '{1'b1, les_pkg::CFG_PULSE_INTERVAL, 11'd0, 1'b0, 8'd0, 1'b0, FRAME_NONE},
        '{1'b1, les_pkg::CFG_FLASH_INTERVAL, 11'd0, 1'b0, 8'd0, 1'b0, FRAME_NONE},
        '{1'b1, les_pkg::CFG_FLASH_PULSES, 11'd0, 1'b0, 8'd0, 1'b0, FRAME_NONE},
        '{1'b0, CFG_NONE, 11'd0, 1'b1, 8'd1, 1'b1, FRAME_WHITE},
        '{1'b0, CFG_NONE, 11'd0, 1'b1, 8'd1, 1'b1, FRAME_RED_FIRST},
        '{1'b0, CFG_NONE, 11'd0, 1'b1, 8'd12, 1'b0, FRAME_NONE},
        '{1'b0, CFG_NONE, 11'd0, 1'b0, 8'd2, 1'b0, FRAME_NONE},
        '{1'b1, les_pkg::CFG_FLASH_PULSES, 11'd2, 1'b0, 8'd0, 1'b0, FRAME_NONE},
        '{1'b1, les_pkg::CFG_FLASH_INTERVAL, 11'd1, 1'b0, 8'd0, 1'b0, FRAME_NONE},
        '{1'b0, CFG_NONE, 11'd0, 1'b1, 8'd1, 1'b0, FRAME_NONE},
        '{1'b0, CFG_NONE, 11'd0, 1'b1, 8'd1, 1'b1, FRAME_WHITE},
        '{1'b0, CFG_NONE, 11'd0, 1'b1, 8'd1, 1'b1, FRAME_BLACK},
        '{1'b0, CFG_NONE, 11'd0, 1'b0, 8'd2, 1'b0, FRAME_NONE},
        '{1'b0, CFG_NONE, 11'd0, 1'b1, 8'd4, 1'b0, FRAME_NONE},
        '{1'b1, les_pkg::CFG_IDLE_RED, 11'd255, 1'b0, 8'd0, 1'b0, FRAME_NONE},
        '{1'b1, les_pkg::CFG_IDLE_BLUE, 11'd2, 1'b0, 8'd0, 1'b0, FRAME_NONE},
        '{1'b0, CFG_NONE, 11'd0, 1'b0, 8'd4, 1'b0, FRAME_NONE}
    };

    function automatic logic [7:0] toward_target(input logic [7:0] cur, input logic [7:0] tgt);
        int diff;
        diff = int'(tgt) - int'(cur);
        return 8'(int'(cur) + diff / 5);
    endfunction

    function automatic logic [7:0] dim8(input logic [7:0] c, input logic [7:0] s);
        logic [15:0] prod;
        prod = 16'(c) * 16'(s);
        return prod[15:8] + {7'd0, (c != 8'd0) && (s != 8'd0)};
    endfunction

    function automatic void apply_reg(input logic [les_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [les_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            les_pkg::CFG_FADE_INTERVAL:  m_fade_ivl    = data[9:0];
            les_pkg::CFG_PULSE_INTERVAL: m_pulse_ivl   = data[9:0];
            les_pkg::CFG_FLASH_INTERVAL: m_flash_ivl   = data[10:0];
            les_pkg::CFG_FLASH_PULSES:   m_flash_count = data[3:0];
            les_pkg::CFG_IDLE_RED:       m_tgt_red     = data[7:0];
            les_pkg::CFG_IDLE_GREEN:     m_tgt_green   = data[7:0];
            les_pkg::CFG_IDLE_BLUE:      m_tgt_blue    = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic bit advance_tick(input logic moving, output t_led_frame frm);
        logic [7:0] white;
        logic [7:0] red_bright;
        frm = FRAME_NONE;
        if (m_fade_tmr != 16'hFFFF) m_fade_tmr++;
        if (m_flash_tmr != 16'hFFFF) m_flash_tmr++;

        if (!moving) begin
            m_flash_done = 1'b0;
            if (m_fade_tmr < 16'(m_fade_ivl)) return 1'b0;
            m_fade_tmr  = '0;
            m_col_red   = toward_target(m_col_red, m_tgt_red);
            m_col_green = toward_target(m_col_green, m_tgt_green);
            m_col_blue  = toward_target(m_col_blue, m_tgt_blue);
            if (m_bright_up) m_bright = m_bright + 8'd5;
            else m_bright = m_bright - 8'd5;
            if (m_bright >= 8'd150) m_bright_up = 1'b0;
            if (m_bright <= 8'd50) m_bright_up = 1'b1;
            frm = '{dim8(m_col_red, m_bright), dim8(m_col_green, m_bright),
                    dim8(m_col_blue, m_bright), les_pkg::EFF_IDLE};
            return 1'b1;
        end

        if (!m_flash_done) begin
            if (!m_flash_on) begin
                m_flash_tmr   = '0;
                m_flash_edges = '0;
                m_flash_on    = 1'b1;
            end
            if (m_flash_tmr < 16'(m_flash_ivl)) return 1'b0;
            m_flash_tmr   = '0;
            m_flash_edges = m_flash_edges + 5'd1;
            white = m_flash_edges[0] ? 8'd255 : 8'd0;
            if (m_flash_edges >= {m_flash_count, 1'b0}) begin
                m_flash_on   = 1'b0;
                m_flash_done = 1'b1;
            end
            frm = '{dim8(white, white), dim8(white, white), dim8(white, white),
                    les_pkg::EFF_FLASH};
            return 1'b1;
        end

        if (m_fade_tmr < 16'(m_pulse_ivl)) return 1'b0;
        m_fade_tmr = '0;
        if (m_red_up) m_red_lvl = m_red_lvl + 9'd20;
        else m_red_lvl = m_red_lvl - 9'd20;
        if (m_red_lvl >= 9'd255) m_red_up = 1'b0;
        if (m_red_lvl <= 9'd50) m_red_up = 1'b1;
        red_bright = (m_red_lvl > 9'd255) ? 8'd255 : m_red_lvl[7:0];
        frm = '{dim8(8'd255, red_bright), dim8(8'd0, red_bright),
                dim8(8'd0, red_bright), les_pkg::EFF_RED};
        return 1'b1;
    endfunction

    function automatic int pick_interval(input int top);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 0;
        if (r < 75) return $urandom_range(1, 6);
        if (r < 95) return $urandom_range(7, 40);
        return top;
    endfunction

    task automatic offer_tick(input logic moving, input bit typed, input t_led_frame want);
        t_led_frame got;
        bit         has;
        while (!no_idle && $urandom_range(0, 99) < 30) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.motor_moving <= moving;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        has = advance_tick(moving, got);
        if (typed) expected_frames.push_back(want);
        else if (has) expected_frames.push_back(got);
    endtask

    // drop valid, wait for every expected frame, then let in-flight ticks retire
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [les_pkg::CFG_IDX_W-1:0] idx,
                             input logic [les_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    initial begin : sink_side
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                hold_out = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (OUT_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 30);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_frames.size() == 0) begin
                $error("unexpected frame: red %0d green %0d blue %0d effect %0d",
                       out_ch.led_red, out_ch.led_green, out_ch.led_blue, out_ch.effect);
                mismatches++;
            end else begin
                oldest = expected_frames.pop_front();
                if (out_ch.led_red !== oldest.led_red) begin
                    $error("led_red: expected %0d, got %0d", oldest.led_red, out_ch.led_red);
                    mismatches++;
                end
                if (out_ch.led_green !== oldest.led_green) begin
                    $error("led_green: expected %0d, got %0d", oldest.led_green, out_ch.led_green);
                    mismatches++;
                end
                if (out_ch.led_blue !== oldest.led_blue) begin
                    $error("led_blue: expected %0d, got %0d", oldest.led_blue, out_ch.led_blue);
                    mismatches++;
                end
                if (out_ch.effect !== oldest.effect) begin
                    $error("effect: expected %0d, got %0d", oldest.effect, out_ch.effect);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : main_seq
        int         sent;
        int         run_len;
        logic       moving;
        int         fade_v, pulse_v, flash_v, count_v;
        logic [7:0] red_v, green_v, blue_v;

        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.motor_moving = 1'b0;

        m_fade_ivl    = 10'd30;
        m_pulse_ivl   = 10'd30;
        m_flash_ivl   = 11'd150;
        m_flash_count = 4'd3;
        m_tgt_red     = 8'd0;
        m_tgt_green   = 8'd0;
        m_tgt_blue    = 8'd255;
        m_fade_tmr    = '0;
        m_flash_tmr   = '0;
        m_col_red     = 8'd0;
        m_col_green   = 8'd0;
        m_col_blue    = 8'd255;
        m_bright      = 8'd50;
        m_bright_up   = 1'b1;
        m_red_lvl     = 9'd50;
        m_red_up      = 1'b1;
        m_flash_on    = 1'b0;
        m_flash_edges = '0;
        m_flash_done  = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                write_reg(plan[i].idx, plan[i].data);
                cfg_we <= 1'b0;
            end else begin
                repeat (plan[i].rep) offer_tick(plan[i].moving, plan[i].typed, plan[i].frm);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            if (ph == 1) begin
                fade_v = 0; pulse_v = 0; flash_v = 0; count_v = 0;
                red_v = 8'd0; green_v = 8'd0; blue_v = 8'd0;
            end else if (ph == 2) begin
                fade_v = 1023; pulse_v = 1023; flash_v = 2047; count_v = 15;
                red_v = 8'd255; green_v = 8'd255; blue_v = 8'd255;
            end else begin
                fade_v  = pick_interval(1023);
                pulse_v = pick_interval(1023);
                flash_v = pick_interval(2047);
                count_v = ($urandom_range(0, 99) < 10) ? 0 :
                          ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) :
                          $urandom_range(5, 15);
                red_v   = 8'($urandom_range(0, 255));
                green_v = 8'($urandom_range(0, 255));
                blue_v  = 8'($urandom_range(0, 255));
            end
            write_reg(les_pkg::CFG_FADE_INTERVAL, 11'(fade_v) | (11'($urandom) & 11'h400));
            write_reg(les_pkg::CFG_PULSE_INTERVAL, 11'(pulse_v) | (11'($urandom) & 11'h400));
            write_reg(les_pkg::CFG_FLASH_INTERVAL, 11'(flash_v));
            write_reg(les_pkg::CFG_FLASH_PULSES, 11'(count_v) | (11'($urandom) & 11'h7F0));
            write_reg(les_pkg::CFG_IDLE_RED, {3'($urandom), red_v});
            write_reg(les_pkg::CFG_IDLE_GREEN, {3'($urandom), green_v});
            write_reg(les_pkg::CFG_IDLE_BLUE, {3'($urandom), blue_v});
            write_reg(CFG_NONE, 11'($urandom));
            cfg_we <= 1'b0;

            no_idle = (ph == 3);
            if (ph == 1) hold_out = 1'b1;

            if (ph == 2) begin
                repeat (EXTREME_TICKS) offer_tick(1'b0, 1'b0, FRAME_NONE);
                repeat (EXTREME_TICKS) offer_tick(1'b1, 1'b0, FRAME_NONE);
            end else begin
                sent = 0;
                while (sent < PHASE_TICKS) begin
                    if ($urandom_range(0, 99) < 85) begin
                        run_len = $urandom_range(1, 40);
                        moving  = ($urandom_range(0, 99) < 60);
                    end else begin
                        run_len = 1;
                        moving  = 1'($urandom_range(0, 1));
                    end
                    repeat (run_len) offer_tick(moving, 1'b0, FRAME_NONE);
                    sent += run_len;
                end
            end
        end

        no_idle = 1'b0;
        settle();
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
